FILE: rtl/fpl2_pkg.sv
// ----------------------------------------------------------------------------
// fpl2_pkg
// Shared widths, stage data type and the log2 step constants for the
// shift-and-add base-2 logarithm core.
// ----------------------------------------------------------------------------
package fpl2_pkg;

    // number of normalisation steps (doubling step included), 8 to 30
    localparam int ITERATIONS = 30;

    localparam int MANT_W  = 31;                  // unsigned q1.30 mantissa
    localparam int LOG_W   = 31;                  // signed q1.30 result
    localparam int ACC_W   = 32;                  // magnitude of the running result
    localparam int SUM_W   = MANT_W + 2;          // trial product before the compare
    localparam int SHIFT_W = $clog2(ITERATIONS);

    localparam logic [ACC_W-1:0] ONE_Q30 = ACC_W'(64'd1 << 30);

    typedef struct packed {
        logic              valid;
        logic [MANT_W-1:0] m;
        logic [ACC_W-1:0]  acc;
    } cell_data_t;

    // log2(1 + 2^-idx) rounded to q1.30, entry 0 is 1.0
    // bits come from repeated squaring of 1 + 2^-idx held in q62
    function automatic logic [LOG_W-1:0] log_entry(input int idx);
        logic [63:0]  y;
        logic [127:0] p;
        logic [31:0]  q;
        int           b;
        y = '0;
        p = '0;
        q = '0;
        if (idx == 0)
        begin
            q = 32'h8000_0000;
        end
        else
        begin
            y = (64'd1 << 62) | (64'd1 << (62 - idx));
            for (b = 0; b < 31; b++)
            begin
                p = {64'd0, y} * {64'd0, y};
                y = p[125:62];
                q = {q[30:0], 1'b0};
                if (y[63])
                begin
                    q[0] = 1'b1;
                    y    = y >> 1;
                end
            end
        end
        return LOG_W'((33'(q) + 33'd1) >> 1);
    endfunction

endpackage

FILE: rtl/fpl2_req_if.sv
// ----------------------------------------------------------------------------
// fpl2_req_if
// Request channel carrying one normalised mantissa per transfer.
// ----------------------------------------------------------------------------
interface fpl2_req_if
    import fpl2_pkg::*;
    ;

    logic              valid;
    logic              ready;
    logic [MANT_W-1:0] mantissa;

    modport source (output valid, output mantissa, input ready);
    modport sink   (input valid, input mantissa, output ready);

endinterface

FILE: rtl/fpl2_rsp_if.sv
// ----------------------------------------------------------------------------
// fpl2_rsp_if
// Result channel carrying one signed q1.30 logarithm per transfer.
// ----------------------------------------------------------------------------
interface fpl2_rsp_if
    import fpl2_pkg::*;
    ;

    logic                    valid;
    logic                    ready;
    logic signed [LOG_W-1:0] log_value;

    modport source (output valid, output log_value, input ready);
    modport sink   (input valid, input log_value, output ready);

endinterface

FILE: rtl/fpl2_cell.sv
// ----------------------------------------------------------------------------
// fpl2_cell
// One normalisation step: tries m + round(m >> shift), keeps it when the
// product stays at or below 1.0 and then adds the step constant to the
// result magnitude. Registered, advances on en.
// ----------------------------------------------------------------------------
module fpl2_cell
    import fpl2_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic [SHIFT_W-1:0] shift,
    input  logic [LOG_W-1:0]   tab,
    input  cell_data_t         d_in,
    output cell_data_t         d_out
);

    logic              valid_reg;
    logic [MANT_W-1:0] m_reg;
    logic [ACC_W-1:0]  acc_reg;

    logic [SUM_W-1:0]  rnd;
    logic [SUM_W-1:0]  incr;
    logic [SUM_W-1:0]  trial;
    logic              take;
    logic [MANT_W-1:0] m_next;
    logic [ACC_W-1:0]  acc_next;

    always_comb
    begin
        // half an lsb of the shifted term, none for the doubling step
        if (shift == '0)
        begin
            rnd = '0;
        end
        else
        begin
            rnd = SUM_W'(1) << (shift - SHIFT_W'(1));
        end
        incr     = (SUM_W'(d_in.m) + rnd) >> shift;
        trial    = SUM_W'(d_in.m) + incr;
        take     = (trial <= SUM_W'(ONE_Q30));
        m_next   = take ? trial[MANT_W-1:0] : d_in.m;
        acc_next = take ? (d_in.acc + ACC_W'(tab)) : d_in.acc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= d_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg   <= m_next;
            acc_reg <= acc_next;
        end
    end

    assign d_out.valid = valid_reg;
    assign d_out.m     = m_reg;
    assign d_out.acc   = acc_reg;

endmodule

FILE: rtl/fixed_point_log2_shift_add_core.sv
// ----------------------------------------------------------------------------
// fixed_point_log2_shift_add_core
// Base-2 logarithm of a normalised mantissa by multiplicative normalisation.
// ----------------------------------------------------------------------------
// usage
// - req: one request per transfer, mantissa in unsigned q1.30, meant to lie
//   within [0.5, 1.0]; a transfer happens when valid and ready are both high
// - rsp: one result per request, log_value = log2(mantissa) in signed q1.30,
//   saturated at -1.0; results leave in request order
// - each request passes through the chain of normalisation cells and then
//   through the output register
// - throughput is one request per cycle unless rsp stalls; the ITERATIONS cells
//   and the output register each hold one of up to ITERATIONS + 1 requests
// - when the receiver stalls with a result waiting, the whole chain holds
//   and req.ready drops in the same cycle; nothing is lost or repeated
// - bubbles move through the chain as invalid entries, so gaps on req are
//   harmless
// - reset clears every valid flag at once; the block takes requests from
//   the first cycle after reset is released
// - above 1.0 no step is taken and the result is 0
// ----------------------------------------------------------------------------
module fixed_point_log2_shift_add_core
    import fpl2_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    fpl2_req_if.sink   req,
    fpl2_rsp_if.source rsp
);

    // chain advances whenever the output register is free or being drained
    logic       en;

    // stage[0] is the incoming request, stage[k+1] the output of cell k
    cell_data_t stage [ITERATIONS+1];

    // output register
    logic             out_valid_reg;
    logic [LOG_W-1:0] out_value_reg;
    logic [ACC_W-1:0] sat_acc;
    logic [LOG_W-1:0] out_value_next;

    assign en        = !out_valid_reg || rsp.ready;
    assign req.ready = en;

    assign stage[0].valid = req.valid;
    assign stage[0].m     = req.mantissa;
    assign stage[0].acc   = '0;

    // one cell per step; step 0 is the doubling, step k adds m >> k rounded
    for (genvar k = 0; k < ITERATIONS; k++)
    begin : g_cell
        localparam logic [LOG_W-1:0] TabK = log_entry(k);

        fpl2_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .shift (SHIFT_W'(k)),
            .tab   (TabK),
            .d_in  (stage[k]),
            .d_out (stage[k+1])
        );
    end

    // clamp the magnitude to 1.0, then negate into the signed result
    always_comb
    begin
        sat_acc        = (stage[ITERATIONS].acc > ONE_Q30) ? ONE_Q30
                                                           : stage[ITERATIONS].acc;
        out_value_next = LOG_W'(0) - sat_acc[LOG_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= stage[ITERATIONS].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_value_reg <= out_value_next;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.log_value = $signed(out_value_reg);

endmodule
